// ===== hw/rtl/conv3x3_bn_relu_plane_macros.svh =====
// Assertion macros shared by the conv3x3_bn_relu_plane checker.
`ifndef CONV3X3_BN_RELU_PLANE_MACROS_SVH
`define CONV3X3_BN_RELU_PLANE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CBR_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CBR_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/cbr_pkg.sv =====
// Types, constants and helpers shared by the conv3x3_bn_relu_plane design.
`timescale 1ns / 1ps
package cbr_pkg;

    localparam int POS_W   = 10;  // row/column index, widest supported plane
    localparam int CNT_W   = 11;  // counters and effective dimensions
    localparam int TAP_N   = 9;
    localparam int Q_DEPTH = 4;
    localparam int SUM_W   = 36;  // nine 32-bit products

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam logic [2:0] REG_IMG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_IN_CHANNELS = 3'd2;
    localparam logic [2:0] REG_BIAS        = 3'd3;
    localparam logic [2:0] REG_BN_SCALE    = 3'd4;
    localparam logic [2:0] REG_BN_SHIFT    = 3'd5;
    localparam logic [2:0] REG_RELU_ENABLE = 3'd6;

    typedef struct packed {
        logic               kind;
        logic [3:0]         weight_index;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic [6:0]         out_row;
        logic [6:0]         out_col;
        logic               run_last;
        logic               plane_done;
    } res_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]   w;
        logic [CNT_W-1:0]   h;
        logic [CNT_W-1:0]   nc;
        logic signed [31:0] bias;
        logic signed [15:0] scale;
        logic signed [15:0] shift;
        logic               relu;
    } cfg_t;

    typedef struct packed {
        logic               is_pixel;
        logic [3:0]         tap_idx;
        logic signed [15:0] value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [1:0]         mod3;
        logic               first_ch;
        logic               last_ch;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE, B_NEXT, B_RD, B_MUL, B_SUM, B_ARD, B_AWR, B_F1, B_F2, B_F3, B_ADV
    } back_state_t;

    // (m + d) mod 3 for m, d in 0..2
    function automatic logic [1:0] mod3_add(input logic [1:0] m, input logic [1:0] d);
        logic [2:0] s;
        s = {1'b0, m} + {1'b0, d};
        if (s >= 3'd3)
            s = s - 3'd3;
        return s[1:0];
    endfunction

endpackage

// ===== hw/rtl/cbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/cbr_queue.sv =====
// Small command FIFO between the front and back parts.
`timescale 1ns / 1ps
module cbr_queue
    import cbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);
    localparam int QA_W = $clog2(Q_DEPTH);

    cmd_t              mem_reg [Q_DEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QA_W:0]     count_reg;

    assign full  = (count_reg == (QA_W+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hw/rtl/cbr_front.sv =====
// Front part: takes input transfers, tracks raster position, queues commands.
`timescale 1ns / 1ps
module cbr_front
    import cbr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     pix_valid,
    output logic     pix_stall,
    input  in_item_t pix_data,
    output logic     q_push,
    output cmd_t     q_data,
    input  logic     q_full
);
    logic [CNT_W-1:0] row_reg, col_reg, ch_reg;
    logic [CNT_W-1:0] row_next, col_next, ch_next;
    logic [1:0]       m3_reg, m3_next;
    logic [CNT_W-1:0] r0, c0, ch0;
    logic [1:0]       m0;

    assign pix_stall = q_full;
    assign q_push    = pix_valid && !q_full;

    always_comb
    begin
        // position of this pixel, wrapping stale counters
        r0  = row_reg;
        c0  = col_reg;
        ch0 = ch_reg;
        m0  = m3_reg;
        if (c0 >= cfg.w)
        begin
            c0 = '0;
            r0 = r0 + 1'b1;
            m0 = mod3_add(m0, 2'd1);
        end
        if (r0 >= cfg.h)
        begin
            r0  = '0;
            m0  = '0;
            ch0 = ch0 + 1'b1;
        end
        if (ch0 >= cfg.nc)
        begin
            ch0 = '0;
        end

        // position of the next pixel
        col_next = c0 + 1'b1;
        row_next = r0;
        m3_next  = m0;
        ch_next  = ch0;
        if (col_next >= cfg.w)
        begin
            col_next = '0;
            row_next = r0 + 1'b1;
            m3_next  = mod3_add(m0, 2'd1);
            if (row_next >= cfg.h)
            begin
                row_next = '0;
                m3_next  = '0;
                ch_next  = ch0 + 1'b1;
                if (ch_next >= cfg.nc)
                begin
                    ch_next = '0;
                end
            end
        end

        q_data.is_pixel = (pix_data.kind == KIND_PIXEL);
        q_data.tap_idx  = pix_data.weight_index;
        q_data.value    = pix_data.value;
        q_data.row      = r0[POS_W-1:0];
        q_data.col      = c0[POS_W-1:0];
        q_data.mod3     = m0;
        q_data.first_ch = (ch0 == '0);
        q_data.last_ch  = (ch0 == cfg.nc - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            ch_reg  <= '0;
            m3_reg  <= '0;
        end
        else if (q_push && pix_data.kind == KIND_PIXEL)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            ch_reg  <= ch_next;
            m3_reg  <= m3_next;
        end
    end
endmodule

// ===== hw/rtl/cbr_back.sv =====
// Back part: line store, tap-serial MAC, accumulator plane, normalize and output.
`timescale 1ns / 1ps
module cbr_back
    import cbr_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int ACC_WIDTH  = 48
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      q_head,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_data
);
    localparam int LA_W = $clog2(3 * MAX_WIDTH);
    localparam int AA_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [1:0]         k_reg, k_next, ky_reg, ky_next, kx_reg, kx_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [31:0] prod_reg, prod_next;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic signed [41:0] a_reg, a_next;
    logic signed [57:0] m_reg, m_next;
    logic signed [15:0] taps_reg [TAP_N];
    logic               out_valid_reg, out_valid_next;
    res_item_t          out_data_reg, out_data_next;

    logic                 line_we;
    logic [LA_W-1:0]      line_waddr, line_raddr;
    logic [15:0]          line_rdata;
    logic                 acc_we;
    logic [AA_W-1:0]      acc_addr;
    logic [ACC_WIDTH-1:0] acc_rdata;

    logic [CNT_W-1:0] wm1, hm1;
    logic [3:0]       kv;
    logic             more_after;
    logic [POS_W-1:0] orow, ocol, iw;
    logic [1:0]       om, lrow, dky;
    logic             ih_ok, iw_ok;
    logic [3:0]       tap_sel;
    logic [63:0]      base64, sum64, new64;
    logic signed [64:0] acc_s, acc_sh;
    logic signed [57:0] q_s;
    logic signed [15:0] q_sat;
    logic             out_free;

    cbr_ram #(.WIDTH(16), .DEPTH(3 * MAX_WIDTH)) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (q_head.value),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    cbr_ram #(.WIDTH(ACC_WIDTH), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_acc (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_addr),
        .wdata (acc_next),
        .raddr (acc_addr),
        .rdata (acc_rdata)
    );

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !res_stall;

    always_comb
    begin
        wm1 = cfg.w - 1'b1;
        hm1 = cfg.h - 1'b1;
        kv[0] = (cmd_reg.row != '0) && (cmd_reg.col != '0);
        kv[1] = (cmd_reg.row != '0) && ({1'b0, cmd_reg.col} == wm1);
        kv[2] = ({1'b0, cmd_reg.row} == hm1) && (cmd_reg.col != '0);
        kv[3] = ({1'b0, cmd_reg.row} == hm1) && ({1'b0, cmd_reg.col} == wm1);
        case (k_reg)
            2'd0:    more_after = |kv[3:1];
            2'd1:    more_after = |kv[3:2];
            2'd2:    more_after = kv[3];
            default: more_after = 1'b0;
        endcase

        orow = k_reg[1] ? cmd_reg.row : cmd_reg.row - 1'b1;
        ocol = k_reg[0] ? cmd_reg.col : cmd_reg.col - 1'b1;
        om   = k_reg[1] ? cmd_reg.mod3 : mod3_add(cmd_reg.mod3, 2'd2);
        dky  = (ky_reg == 2'd0) ? 2'd2 : ky_reg - 1'b1;
        lrow = mod3_add(om, dky);
        iw   = ocol + POS_W'(kx_reg) - 1'b1;
        case (ky_reg)
            2'd0:    ih_ok = (orow != '0);
            2'd2:    ih_ok = ({1'b0, orow} < hm1);
            default: ih_ok = 1'b1;
        endcase
        case (kx_reg)
            2'd0:    iw_ok = (ocol != '0);
            2'd2:    iw_ok = ({1'b0, ocol} < wm1);
            default: iw_ok = 1'b1;
        endcase
        tap_sel    = {1'b0, ky_reg, 1'b0} + {2'b0, ky_reg} + {2'b0, kx_reg};
        line_raddr = (ih_ok && iw_ok) ? LA_W'(lrow * MAX_WIDTH + iw) : '0;
        line_waddr = LA_W'(q_head.mod3 * MAX_WIDTH + q_head.col);
        acc_addr   = AA_W'(orow * MAX_WIDTH + ocol);

        // accumulate, wrapping at the accumulator width
        base64 = cmd_reg.first_ch ? {{32{cfg.bias[31]}}, cfg.bias} : 64'(acc_rdata);
        sum64  = {{(64-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
        new64  = base64 + sum64;

        acc_s  = {{(65-ACC_WIDTH){acc_reg[ACC_WIDTH-1]}}, acc_reg};
        acc_sh = acc_s >>> 14;
        q_s    = (m_reg >>> 12) + 58'(cfg.shift);
        if (q_s > 58'sd32767)
            q_sat = 16'sd32767;
        else if (q_s < -58'sd32768)
            q_sat = -16'sd32768;
        else
            q_sat = q_s[15:0];
        if (cfg.relu && q_sat < 0)
            q_sat = '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        k_next         = k_reg;
        ky_next        = ky_reg;
        kx_next        = kx_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        acc_next       = new64[ACC_WIDTH-1:0];
        a_next         = a_reg;
        m_next         = m_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        line_we        = 1'b0;
        acc_we         = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_pixel)
                    begin
                        line_we    = 1'b1;
                        cmd_next   = q_head;
                        k_next     = '0;
                        state_next = B_NEXT;
                    end
                end
            end
            B_NEXT:
            begin
                if (kv[k_reg])
                begin
                    ky_next    = '0;
                    kx_next    = '0;
                    sum_next   = '0;
                    state_next = B_RD;
                end
                else
                begin
                    state_next = B_ADV;
                end
            end
            B_RD:
            begin
                state_next = B_MUL;
            end
            B_MUL:
            begin
                prod_next  = (ih_ok && iw_ok) ? signed'(line_rdata) * taps_reg[tap_sel]
                                              : 32'sd0;
                state_next = B_SUM;
            end
            B_SUM:
            begin
                sum_next = sum_reg + SUM_W'(prod_reg);
                if (ky_reg == 2'd2 && kx_reg == 2'd2)
                begin
                    state_next = B_ARD;
                end
                else
                begin
                    if (kx_reg == 2'd2)
                    begin
                        kx_next = '0;
                        ky_next = ky_reg + 1'b1;
                    end
                    else
                    begin
                        kx_next = kx_reg + 1'b1;
                    end
                    state_next = B_RD;
                end
            end
            B_ARD:
            begin
                state_next = B_AWR;
            end
            B_AWR:
            begin
                acc_we     = 1'b1;
                state_next = cmd_reg.last_ch ? B_F1 : B_ADV;
            end
            B_F1:
            begin
                if (acc_sh > 65'sd1099511627776)
                    a_next = 42'sd1099511627776;
                else if (acc_sh < -65'sd1099511627776)
                    a_next = -42'sd1099511627776;
                else
                    a_next = acc_sh[41:0];
                state_next = B_F2;
            end
            B_F2:
            begin
                m_next     = a_reg * cfg.scale;
                state_next = B_F3;
            end
            B_F3:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.out_value  = q_sat;
                    out_data_next.out_row    = orow[6:0];
                    out_data_next.out_col    = ocol[6:0];
                    out_data_next.run_last   = !more_after;
                    out_data_next.plane_done = ({1'b0, orow} == hm1) && ({1'b0, ocol} == wm1);
                    state_next               = B_ADV;
                end
            end
            B_ADV:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = B_NEXT;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        k_reg        <= k_next;
        ky_reg       <= ky_next;
        kx_reg       <= kx_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        a_reg        <= a_next;
        m_reg        <= m_next;
        out_data_reg <= out_data_next;
        if (acc_we)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == B_IDLE && !q_empty && !q_head.is_pixel
            && q_head.tap_idx < 4'(TAP_N))
        begin
            taps_reg[q_head.tap_idx] <= q_head.value;
        end
    end
endmodule

// ===== hw/rtl/conv3x3_bn_relu_plane.sv =====
// Top level of the 3x3 convolution, folded batch-norm and ReLU plane engine.
`timescale 1ns / 1ps
// conv3x3_bn_relu_plane computes one output channel of a 3x3, stride 1,
// zero-padded convolution over a multi-channel plane. Each transfer on the
// pix channel either loads a Q2.14 kernel tap (kind 0) or delivers a Q8.8
// pixel (kind 1); pixels come in raster order, channel after channel, with
// nine fresh taps loaded before each channel. A front part tracks the raster
// position and pushes commands into a four-entry queue; a back part runs them.
// A weight load is taken by the back part directly in its idle state. A pixel
// goes through bookkeeping for each of its four candidate windows, plus, for
// each window it completes, nine taps through one multiplier (read, multiply
// and sum per tap), then the accumulator read-modify-write, and the normalize
// steps per result on the last channel. An interior pixel completes one window,
// the bottom-right corner four; the single multiplier sets the pace. Results
// leave through an output register, so the back part keeps working while one
// result waits on res_stall. The accumulator plane is seeded from bias on the
// first channel and needs no clearing pass. Configuration goes through the
// APB port at byte address 4*index and must be written only while idle.
module conv3x3_bn_relu_plane
    import cbr_pkg::*;
#(
    parameter int MAX_WIDTH       = 128,
    parameter int MAX_HEIGHT      = 128,
    parameter int MAX_IN_CHANNELS = 1024,
    parameter int ACC_WIDTH       = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_stall,
    input  in_item_t    pix_data,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // raw register values, as written
    logic [7:0]         img_width_reg, img_height_reg;
    logic [10:0]        in_channels_reg;
    logic signed [31:0] bias_reg;
    logic signed [15:0] bn_scale_reg, bn_shift_reg;
    logic               relu_enable_reg;
    logic               cfg_we;
    cfg_t               cfg;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_data, q_head;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg   <= 8'd128;
            img_height_reg  <= 8'd128;
            in_channels_reg <= 11'd4;
            bias_reg        <= '0;
            bn_scale_reg    <= 16'sd4096;
            bn_shift_reg    <= '0;
            relu_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_IMG_WIDTH:   img_width_reg   <= pwdata[7:0];
                REG_IMG_HEIGHT:  img_height_reg  <= pwdata[7:0];
                REG_IN_CHANNELS: in_channels_reg <= pwdata[10:0];
                REG_BIAS:        bias_reg        <= pwdata;
                REG_BN_SCALE:    bn_scale_reg    <= pwdata[15:0];
                REG_BN_SHIFT:    bn_shift_reg    <= pwdata[15:0];
                REG_RELU_ENABLE: relu_enable_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_IMG_WIDTH:   prdata = 32'(img_width_reg);
            REG_IMG_HEIGHT:  prdata = 32'(img_height_reg);
            REG_IN_CHANNELS: prdata = 32'(in_channels_reg);
            REG_BIAS:        prdata = bias_reg;
            REG_BN_SCALE:    prdata = 32'(unsigned'(bn_scale_reg));
            REG_BN_SHIFT:    prdata = 32'(unsigned'(bn_shift_reg));
            REG_RELU_ENABLE: prdata = 32'(relu_enable_reg);
            default:         prdata = '0;
        endcase
    end

    // effective dimensions: zero reads as one, large values clamp to the max
    always_comb
    begin
        if (img_width_reg == '0)
            cfg.w = CNT_W'(1);
        else if (32'(img_width_reg) > MAX_WIDTH)
            cfg.w = CNT_W'(MAX_WIDTH);
        else
            cfg.w = CNT_W'(img_width_reg);
        if (img_height_reg == '0)
            cfg.h = CNT_W'(1);
        else if (32'(img_height_reg) > MAX_HEIGHT)
            cfg.h = CNT_W'(MAX_HEIGHT);
        else
            cfg.h = CNT_W'(img_height_reg);
        if (in_channels_reg == '0)
            cfg.nc = CNT_W'(1);
        else if (32'(in_channels_reg) > MAX_IN_CHANNELS)
            cfg.nc = CNT_W'(MAX_IN_CHANNELS);
        else
            cfg.nc = in_channels_reg;
        cfg.bias  = bias_reg;
        cfg.scale = bn_scale_reg;
        cfg.shift = bn_shift_reg;
        cfg.relu  = relu_enable_reg;
    end

    cbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .q_push    (q_push),
        .q_data    (q_data),
        .q_full    (q_full)
    );

    cbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    cbr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );
endmodule

// ===== hw/rtl/cbr_checker.sv =====
// Port-level checker for conv3x3_bn_relu_plane, bound to the top level.
`timescale 1ns / 1ps
`include "conv3x3_bn_relu_plane_macros.svh"
module cbr_checker
    import cbr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res_data,
    input logic      pready
);
    // a stalled result transfer holds
    `CBR_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data))
    // the plane's final pixel always closes the run of its input
    `CBR_IMPLY(a_done_last, res_valid && res_data.plane_done, res_data.run_last)
    // config port never inserts wait states
    `CBR_IMPLY(a_pready, 1'b1, pready)
endmodule

bind conv3x3_bn_relu_plane cbr_checker u_cbr_checker (.*);
